### rtl/core/calst_pkg.sv
// Shared types, constants and codes of the capacity-aware load split table.
// Used by every module of the block; depends on nothing.
`default_nettype none

package calst_pkg;

    localparam int MAX_WORKERS = 8;
    localparam int BUCKETS     = 1024;
    localparam int FILES       = 16;

    localparam int WIDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int WCNT_W       = $clog2(MAX_WORKERS + 1);
    localparam int BIDX_W       = $clog2(BUCKETS);
    localparam int BCNT_W       = $clog2(BUCKETS + 1);
    localparam int FILE_IDX_W   = (FILES > 1) ? $clog2(FILES) : 1;
    localparam int SHARE_ADDR_W = $clog2(FILES * MAX_WORKERS);
    localparam int BKT_ADDR_W   = $clog2(FILES * BUCKETS);
    localparam int MAX_ITER     = MAX_WORKERS + 2;
    localparam int ITER_W       = $clog2(MAX_ITER + 1);
    localparam int SHARE_W      = 17;
    localparam int HEAD_W       = SHARE_W + 1;
    localparam int SUM_W        = 32 + WIDX_W;
    localparam int PFX_W        = SHARE_W + WIDX_W + 1;
    localparam int FILL_W       = 48;
    localparam int QSTEPS       = 17;
    localparam int QSTEP_W      = 5;

    localparam logic [SHARE_W-1:0] ONE_Q16 = 17'd65536;
    localparam logic signed [HEAD_W-1:0] EPS_POS = 18'sd66;
    localparam logic signed [HEAD_W-1:0] EPS_NEG = -18'sd66;

    localparam logic CFG_CPU_WORKERS = 1'b0;
    localparam logic CFG_GPU_WORKERS = 1'b1;

    typedef logic signed [HEAD_W-1:0] head_t;

    typedef enum logic [2:0] {
        CMD_RATE      = 3'd0,
        CMD_LIMIT     = 3'd1,
        CMD_UPDATE    = 3'd2,
        CMD_RD_SHARE  = 3'd3,
        CMD_RD_BUCKET = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic        is_gpu;
        logic [2:0]  worker;
        logic [3:0]  file;
        logic [31:0] throughput;
        logic [63:0] capacity;
        logic [63:0] kmer_count;
        logic [9:0]  bucket_index;
    } req_t;

    typedef struct packed {
        logic [16:0] read_data;
        logic        not_ready;
        logic        update_ignored;
        logic        capacity_short;
    } rsp_t;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_WR_REPORT,
        DP_SET_NR,
        DP_SET_IGN,
        DP_RD_ISSUE,
        DP_RD_TAKE,
        DP_SUM_INIT,
        DP_SUM_STEP,
        DP_W_ISSUE,
        DP_W_FIN,
        DP_R_NEXT,
        DP_Y_START,
        DP_Y_STEP,
        DP_XFER,
        DP_SH_WRITE,
        DP_FILL,
        DP_FINISH,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        logic [2:0] command;
        logic       upd_ok;
        logic       rd_ok;
        logic       i_last;
        logic       i_max;
        logic       k_last;
        logic       redist_go;
        logic       div_done;
        logic       ydiv_done;
        logic       fill_done;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_SUM,
        S_W_ISSUE,
        S_W_WAIT,
        S_R_CHECK,
        S_Y_DIV,
        S_XFER,
        S_SH_WRITE,
        S_FILL,
        S_RESP
    } ctrl_state_t;

endpackage

`default_nettype wire

### rtl/core/calst_qdiv.sv
// Serial fraction divider: floor(num * 65536 / den), one quotient bit per cycle.
// Depends on calst_pkg.
`default_nettype none

module calst_qdiv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output logic [16:0]      quot,
    output logic             done
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [calst_pkg::QSTEP_W-1:0] step_reg, step_next;
    logic [63:0]                   rem_reg, rem_next;
    logic [63:0]                   den_reg, den_next;
    logic [16:0]                   q_reg, q_next;
    logic [64:0]                   trial;
    logic                          ge;

    // The first step compares without doubling, giving the integer bit.
    always_comb
    begin
        trial = (step_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        ge    = trial >= {1'b0, den_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = '0;
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? 64'(trial - {1'b0, den_reg}) : trial[63:0];
            q_next    = {q_reg[15:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == calst_pkg::QSTEP_W'(calst_pkg::QSTEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

### rtl/core/calst_ctrl.sv
// Controller state machine: sequences request decode, share computation,
// redistribution and table fill. Depends on calst_pkg.
`default_nettype none

module calst_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire calst_pkg::dp_stat_t stat,
    output calst_pkg::dp_op_t        op
);

    calst_pkg::ctrl_state_t state_reg, state_next;
    logic                   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= calst_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        op             = calst_pkg::DP_NOP;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            calst_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = calst_pkg::DP_CAPTURE;
                    state_next = calst_pkg::S_DECODE;
                end
            end
            calst_pkg::S_DECODE:
            begin
                unique case (calst_pkg::cmd_t'(stat.command))
                    calst_pkg::CMD_RATE, calst_pkg::CMD_LIMIT:
                    begin
                        op         = calst_pkg::DP_WR_REPORT;
                        state_next = calst_pkg::S_RESP;
                    end
                    calst_pkg::CMD_UPDATE:
                    begin
                        if (stat.upd_ok)
                        begin
                            op         = calst_pkg::DP_SUM_INIT;
                            state_next = calst_pkg::S_SUM;
                        end
                        else
                        begin
                            op         = calst_pkg::DP_SET_IGN;
                            state_next = calst_pkg::S_RESP;
                        end
                    end
                    calst_pkg::CMD_RD_SHARE, calst_pkg::CMD_RD_BUCKET:
                    begin
                        if (stat.rd_ok)
                        begin
                            op         = calst_pkg::DP_RD_ISSUE;
                            state_next = calst_pkg::S_RD_WAIT;
                        end
                        else
                        begin
                            op         = calst_pkg::DP_SET_NR;
                            state_next = calst_pkg::S_RESP;
                        end
                    end
                    default:
                    begin
                        state_next = calst_pkg::S_RESP;
                    end
                endcase
            end
            calst_pkg::S_RD_WAIT:
            begin
                op         = calst_pkg::DP_RD_TAKE;
                state_next = calst_pkg::S_RESP;
            end
            calst_pkg::S_SUM:
            begin
                op = calst_pkg::DP_SUM_STEP;
                if (stat.i_last)
                begin
                    state_next = calst_pkg::S_W_ISSUE;
                end
            end
            calst_pkg::S_W_ISSUE:
            begin
                op         = calst_pkg::DP_W_ISSUE;
                state_next = calst_pkg::S_W_WAIT;
            end
            calst_pkg::S_W_WAIT:
            begin
                if (stat.div_done)
                begin
                    op         = calst_pkg::DP_W_FIN;
                    state_next = stat.i_last ? calst_pkg::S_R_CHECK : calst_pkg::S_W_ISSUE;
                end
            end
            calst_pkg::S_R_CHECK:
            begin
                if (stat.redist_go)
                begin
                    op         = calst_pkg::DP_Y_START;
                    state_next = calst_pkg::S_Y_DIV;
                end
                else
                begin
                    op = calst_pkg::DP_R_NEXT;
                    if (stat.i_last)
                    begin
                        state_next = calst_pkg::S_SH_WRITE;
                    end
                end
            end
            calst_pkg::S_Y_DIV:
            begin
                op = calst_pkg::DP_Y_STEP;
                if (stat.ydiv_done)
                begin
                    state_next = calst_pkg::S_XFER;
                end
            end
            calst_pkg::S_XFER:
            begin
                op = calst_pkg::DP_XFER;
                if (stat.k_last)
                begin
                    state_next = calst_pkg::S_R_CHECK;
                end
            end
            calst_pkg::S_SH_WRITE:
            begin
                op = calst_pkg::DP_SH_WRITE;
                if (stat.i_max)
                begin
                    state_next = calst_pkg::S_FILL;
                end
            end
            calst_pkg::S_FILL:
            begin
                if (stat.fill_done)
                begin
                    op         = calst_pkg::DP_FINISH;
                    state_next = calst_pkg::S_RESP;
                end
                else
                begin
                    op = calst_pkg::DP_FILL;
                end
            end
            calst_pkg::S_RESP:
            begin
                // The result waits here until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    op             = calst_pkg::DP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = calst_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = calst_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### rtl/core/calst_dp.sv
// Datapath: report stores, configuration, share and bucket memories, share
// computation, redistribution and bucket fill. Depends on calst_pkg, calst_qdiv.
`default_nettype none

module calst_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic              cfg_index,
    input  wire logic [3:0]        cfg_data,
    input  wire calst_pkg::req_t   in_data,
    input  wire calst_pkg::dp_op_t op,
    output calst_pkg::dp_stat_t    stat,
    output calst_pkg::rsp_t        out_data
);

    localparam int MW = calst_pkg::MAX_WORKERS;
    localparam int WI = calst_pkg::WIDX_W;
    localparam int WC = calst_pkg::WCNT_W;
    localparam int SW = calst_pkg::SHARE_W;

    logic [3:0]                 cpu_reg, gpu_reg;
    logic [31:0]                rate_reg [MW];
    logic [63:0]                limit_reg [MW];
    logic [calst_pkg::FILES-1:0] done_reg;
    logic [3:0]                 prev_file_reg;
    calst_pkg::req_t            req_reg;
    calst_pkg::rsp_t            res_reg, out_reg;
    logic [SW-1:0]              share_reg [MW];
    calst_pkg::head_t           head_reg [MW];
    logic [WI-1:0]              i_reg, k_reg, b_reg;
    logic [calst_pkg::ITER_W-1:0] it_reg;
    logic [calst_pkg::BCNT_W-1:0] j_reg;
    logic [calst_pkg::PFX_W-1:0]  prefix_reg;
    logic [calst_pkg::SUM_W-1:0]  sum_reg;
    logic                       zero_reg, short_reg;
    logic [16:0]                y_q_reg;
    logic [3:0]                 y_rem_reg;
    logic [WC-1:0]              y_den_reg;
    logic [calst_pkg::QSTEP_W-1:0] y_cnt_reg;

    logic [SW-1:0]              share_mem [calst_pkg::FILES * MW];
    logic [WI-1:0]              bucket_mem [calst_pkg::FILES * calst_pkg::BUCKETS];
    logic [SW-1:0]              share_rd_reg;
    logic [WI-1:0]              bucket_rd_reg;

    logic [4:0]                 total;
    logic [WC-1:0]              n_w;
    logic [4:0]                 idx;
    logic                       idx_ok;
    logic                       file_ok, file_done;
    logic [calst_pkg::FILE_IDX_W-1:0] f_idx;
    logic                       i_last, k_last;
    logic [WI-1:0]              i_wrap;
    logic [MW-1:0]              open_vec;
    logic [WC-1:0]              open_cnt;
    calst_pkg::head_t           h_i, h_k;
    logic                       redist_go;
    logic [16:0]                frac_q, cap_q;
    logic                       frac_done, cap_done;
    logic                       div_start;
    logic [63:0]                frac_num, frac_den;
    logic [SW-1:0]              prev_share, cap_val, new_share;
    logic [4:0]                 y_trial;
    logic                       y_ge;
    logic [16:0]                x_amt;
    logic [calst_pkg::PFX_W-1:0] fill_next;
    logic                       fill_hit;
    logic [calst_pkg::SHARE_ADDR_W-1:0] sh_rd_addr, sh_wr_addr;
    logic [calst_pkg::BKT_ADDR_W-1:0]   bk_rd_addr, bk_wr_addr;

    // Worker count, clamped to one at the low end and the store size at the top.
    always_comb
    begin
        total = {1'b0, cpu_reg} + {1'b0, gpu_reg};
        if (total == '0)
        begin
            n_w = WC'(1);
        end
        else if (total > 5'(MW))
        begin
            n_w = WC'(MW);
        end
        else
        begin
            n_w = WC'(total);
        end
    end

    always_comb
    begin
        idx       = req_reg.is_gpu ? ({1'b0, cpu_reg} + {2'b00, req_reg.worker})
                                   : {2'b00, req_reg.worker};
        idx_ok    = idx < 5'(MW);
        f_idx     = req_reg.file[calst_pkg::FILE_IDX_W-1:0];
        file_ok   = 32'(req_reg.file) < calst_pkg::FILES;
        file_done = done_reg[f_idx];
        i_last    = (WC'(i_reg) + WC'(1)) == n_w;
        k_last    = (WC'(k_reg) + WC'(1)) == n_w;
        i_wrap    = i_last ? '0 : i_reg + 1'b1;
        h_i       = head_reg[i_reg];
        h_k       = head_reg[k_reg];
    end

    always_comb
    begin
        open_cnt = '0;
        for (int k = 0; k < MW; k++)
        begin
            open_vec[k] = (k < 32'(n_w)) && (head_reg[k] > calst_pkg::EPS_POS);
            if (open_vec[k])
            begin
                open_cnt = open_cnt + WC'(1);
            end
        end
        redist_go = (h_i < calst_pkg::EPS_NEG) && (open_cnt != '0)
                    && (it_reg < calst_pkg::ITER_W'(calst_pkg::MAX_ITER));
    end

    // With an unreported throughput the same divider gives 65536 / n.
    assign div_start = (op == calst_pkg::DP_W_ISSUE);
    assign frac_num  = zero_reg ? 64'd1 : 64'(rate_reg[i_reg]);
    assign frac_den  = zero_reg ? 64'(n_w) : 64'(sum_reg);

    calst_qdiv u_frac_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (frac_num),
        .den   (frac_den),
        .quot  (frac_q),
        .done  (frac_done)
    );

    calst_qdiv u_cap_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (limit_reg[i_reg]),
        .den   (req_reg.kmer_count),
        .quot  (cap_q),
        .done  (cap_done)
    );

    always_comb
    begin
        prev_share = done_reg[prev_file_reg[calst_pkg::FILE_IDX_W-1:0]] ? share_rd_reg : '0;
        if ((req_reg.kmer_count == '0) || (limit_reg[i_reg] >= req_reg.kmer_count))
        begin
            cap_val = calst_pkg::ONE_Q16;
        end
        else
        begin
            cap_val = cap_q;
        end
        new_share = zero_reg ? frac_q
                             : SW'(({1'b0, prev_share} + {1'b0, frac_q}) >> 1);
    end

    always_comb
    begin
        y_trial = {y_rem_reg, y_q_reg[16]};
        y_ge    = y_trial >= 5'(y_den_reg);
        x_amt   = ($signed({1'b0, y_q_reg}) < h_k) ? y_q_reg : h_k[16:0];
    end

    always_comb
    begin
        if (WC'(b_reg) + WC'(1) == n_w)
        begin
            fill_next = calst_pkg::PFX_W'(calst_pkg::ONE_Q16);
        end
        else
        begin
            fill_next = prefix_reg + calst_pkg::PFX_W'(share_reg[b_reg]);
        end
        fill_hit = (calst_pkg::FILL_W'(j_reg) << 16)
                   <= (calst_pkg::FILL_W'(fill_next) * calst_pkg::FILL_W'(calst_pkg::BUCKETS));
    end

    always_comb
    begin
        sh_rd_addr = (op == calst_pkg::DP_W_ISSUE)
            ? calst_pkg::SHARE_ADDR_W'(prev_file_reg) * calst_pkg::SHARE_ADDR_W'(MW)
              + calst_pkg::SHARE_ADDR_W'(i_reg)
            : calst_pkg::SHARE_ADDR_W'(req_reg.file) * calst_pkg::SHARE_ADDR_W'(MW)
              + calst_pkg::SHARE_ADDR_W'(idx[WI-1:0]);
        sh_wr_addr = calst_pkg::SHARE_ADDR_W'(req_reg.file) * calst_pkg::SHARE_ADDR_W'(MW)
                     + calst_pkg::SHARE_ADDR_W'(i_reg);
        bk_rd_addr = calst_pkg::BKT_ADDR_W'(req_reg.file)
                     * calst_pkg::BKT_ADDR_W'(calst_pkg::BUCKETS)
                     + calst_pkg::BKT_ADDR_W'(req_reg.bucket_index);
        bk_wr_addr = calst_pkg::BKT_ADDR_W'(req_reg.file)
                     * calst_pkg::BKT_ADDR_W'(calst_pkg::BUCKETS)
                     + calst_pkg::BKT_ADDR_W'(j_reg[calst_pkg::BIDX_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if ((op == calst_pkg::DP_W_ISSUE) || (op == calst_pkg::DP_RD_ISSUE))
        begin
            share_rd_reg <= share_mem[sh_rd_addr];
        end
        if (op == calst_pkg::DP_SH_WRITE)
        begin
            share_mem[sh_wr_addr] <= (WC'(i_reg) < n_w) ? share_reg[i_reg] : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == calst_pkg::DP_RD_ISSUE)
        begin
            bucket_rd_reg <= bucket_mem[bk_rd_addr];
        end
        if ((op == calst_pkg::DP_FILL) && fill_hit)
        begin
            bucket_mem[bk_wr_addr] <= b_reg;
        end
    end

    // Configuration, report stores and per-file bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg       <= 4'd4;
            gpu_reg       <= 4'd0;
            done_reg      <= '0;
            prev_file_reg <= '0;
            for (int w = 0; w < MW; w++)
            begin
                rate_reg[w]  <= '0;
                limit_reg[w] <= '1;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == calst_pkg::CFG_CPU_WORKERS)
                begin
                    cpu_reg <= cfg_data;
                end
                else
                begin
                    gpu_reg <= cfg_data;
                end
            end
            if ((op == calst_pkg::DP_WR_REPORT) && idx_ok)
            begin
                if (req_reg.command == calst_pkg::CMD_RATE)
                begin
                    rate_reg[idx[WI-1:0]] <= req_reg.throughput;
                end
                else
                begin
                    limit_reg[idx[WI-1:0]] <= req_reg.capacity;
                end
            end
            if (op == calst_pkg::DP_FINISH)
            begin
                done_reg[f_idx] <= 1'b1;
                prev_file_reg   <= req_reg.file;
            end
        end
    end

    // Work registers of the update sequence and the result registers.
    always_ff @(posedge clk)
    begin
        unique case (op)
            calst_pkg::DP_CAPTURE:
            begin
                req_reg <= in_data;
                res_reg <= '0;
            end
            calst_pkg::DP_SET_NR:
            begin
                res_reg.not_ready <= 1'b1;
            end
            calst_pkg::DP_SET_IGN:
            begin
                res_reg.update_ignored <= 1'b1;
            end
            calst_pkg::DP_RD_TAKE:
            begin
                if (req_reg.command == calst_pkg::CMD_RD_SHARE)
                begin
                    res_reg.read_data <= idx_ok ? share_rd_reg : '0;
                end
                else
                begin
                    res_reg.read_data <= (32'(req_reg.bucket_index) < calst_pkg::BUCKETS)
                                         ? 17'(bucket_rd_reg) : '0;
                end
            end
            calst_pkg::DP_SUM_INIT:
            begin
                i_reg      <= '0;
                it_reg     <= '0;
                sum_reg    <= '0;
                zero_reg   <= 1'b0;
                short_reg  <= 1'b0;
                j_reg      <= '0;
                b_reg      <= '0;
                prefix_reg <= '0;
            end
            calst_pkg::DP_SUM_STEP:
            begin
                sum_reg <= sum_reg + calst_pkg::SUM_W'(rate_reg[i_reg]);
                if (rate_reg[i_reg] == '0)
                begin
                    zero_reg <= 1'b1;
                end
                i_reg <= i_wrap;
            end
            calst_pkg::DP_W_FIN:
            begin
                share_reg[i_reg] <= new_share;
                head_reg[i_reg]  <= $signed({1'b0, cap_val}) - $signed({1'b0, new_share});
                i_reg            <= i_wrap;
            end
            calst_pkg::DP_R_NEXT:
            begin
                if (h_i < calst_pkg::EPS_NEG)
                begin
                    short_reg <= 1'b1;
                end
                i_reg  <= i_wrap;
                it_reg <= '0;
            end
            calst_pkg::DP_Y_START:
            begin
                y_q_reg   <= 17'(-h_i);
                y_rem_reg <= '0;
                y_den_reg <= open_cnt;
                y_cnt_reg <= '0;
                k_reg     <= '0;
            end
            calst_pkg::DP_Y_STEP:
            begin
                y_rem_reg <= y_ge ? 4'(y_trial - 5'(y_den_reg)) : y_trial[3:0];
                y_q_reg   <= {y_q_reg[15:0], y_ge};
                y_cnt_reg <= y_cnt_reg + 1'b1;
            end
            calst_pkg::DP_XFER:
            begin
                if (open_vec[k_reg])
                begin
                    share_reg[i_reg] <= share_reg[i_reg] - x_amt;
                    share_reg[k_reg] <= share_reg[k_reg] + x_amt;
                    head_reg[i_reg]  <= h_i + $signed({1'b0, x_amt});
                    head_reg[k_reg]  <= h_k - $signed({1'b0, x_amt});
                end
                if (k_last)
                begin
                    k_reg  <= '0;
                    it_reg <= it_reg + 1'b1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            calst_pkg::DP_SH_WRITE:
            begin
                i_reg <= i_reg + 1'b1;
            end
            calst_pkg::DP_FILL:
            begin
                if (fill_hit)
                begin
                    j_reg <= j_reg + 1'b1;
                end
                else
                begin
                    prefix_reg <= prefix_reg + calst_pkg::PFX_W'(share_reg[b_reg]);
                    b_reg      <= b_reg + 1'b1;
                end
            end
            calst_pkg::DP_FINISH:
            begin
                res_reg.capacity_short <= short_reg;
            end
            calst_pkg::DP_OUT_LOAD:
            begin
                out_reg <= res_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat.command   = req_reg.command;
        stat.upd_ok    = file_ok && !file_done;
        stat.rd_ok     = file_ok && file_done;
        stat.i_last    = i_last;
        stat.i_max     = i_reg == WI'(MW - 1);
        stat.k_last    = k_last;
        stat.redist_go = redist_go;
        stat.div_done  = frac_done && cap_done;
        stat.ydiv_done = y_cnt_reg == calst_pkg::QSTEP_W'(calst_pkg::QSTEPS - 1);
        stat.fill_done = j_reg == calst_pkg::BCNT_W'(calst_pkg::BUCKETS);
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

### rtl/core/capacity_aware_load_split_table_core.sv
// One request is in flight at a time; the next is accepted once the result
// is in the output register. A file update computes the shares, redistributes
// them, writes the 8 share entries of the file, then fills its 1024 bucket
// entries, each with its worker index.
// Reset is asynchronous, active low; no clearing pass, the bucket table is undefined.
`default_nettype none

module capacity_aware_load_split_table_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire calst_pkg::req_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output calst_pkg::rsp_t      out_data,
    input  wire logic            cfg_write,
    input  wire logic            cfg_index,
    input  wire logic [3:0]      cfg_data
);

    calst_pkg::dp_op_t   op;
    calst_pkg::dp_stat_t stat;

    calst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .op        (op)
    );

    calst_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .op        (op),
        .stat      (stat),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
